[rtl/grwr_pkg.sv]
package grwr_pkg;

	// default window length in counting periods
	localparam int WINDOW_LEN_DEF = 60;

	// field widths
	localparam int EDGE_W     = 16;
	localparam int PULSE_W    = 15;
	localparam int AVG_W      = 23;
	localparam int DOSE_W     = 24;
	localparam int FILL_OUT_W = 6;
	localparam int CFG_W      = 16;
	localparam int AVG_FRAC   = 8;

	// 2560 = 2^11 + 2^9 scales the q8 average into a q16 dose numerator
	localparam int SCALE_SH_HI = 11;
	localparam int SCALE_SH_LO = 9;
	localparam int DOSE_NUM_W  = AVG_W + SCALE_SH_HI + 1;

	localparam logic [CFG_W-1:0]  CFG_RESET = 16'd1538;
	localparam logic [DOSE_W-1:0] DOSE_SAT  = '1;

	localparam int QUEUE_DEPTH = 2;

	localparam int OUT_FIELDS_W = PULSE_W + AVG_W + DOSE_W + FILL_OUT_W;
	localparam int TDATA_OUT_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef enum logic {
		F_IDLE,
		F_UPDATE
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_AVG,
		B_SCALE_MUL,
		B_SCALE_CHK,
		B_DOSE,
		B_OUT
	} back_state_t;

	// bits needed for the sum of a full ring of pulse counts
	function automatic int total_width(input int len);
		return $clog2(len * ((1 << PULSE_W) - 1) + 1);
	endfunction

endpackage

[rtl/grwr_ram.sv]
module grwr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/grwr_front.sv]
module grwr_front
	import grwr_pkg::*;
#(
	parameter int WINDOW_LEN = WINDOW_LEN_DEF,
	parameter int TOTAL_W    = total_width(WINDOW_LEN),
	parameter int FILL_W     = $clog2(WINDOW_LEN + 1),
	parameter int PTR_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1,
	parameter int ITEM_W     = PULSE_W + TOTAL_W + FILL_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [EDGE_W-1:0] s_tdata,
	input  logic              q_full,
	output logic              q_push,
	output logic [ITEM_W-1:0] q_data
);

	front_state_t state_q, state_d;

	logic [PULSE_W-1:0] pulses_q;
	logic [PTR_W-1:0]   ptr_q;
	logic [FILL_W-1:0]  fill_q;
	logic [TOTAL_W-1:0] total_q;

	logic               accept;
	logic               ring_full;
	logic [PULSE_W-1:0] ram_rdata;
	logic [PULSE_W-1:0] oldest;
	logic [TOTAL_W-1:0] total_new;
	logic [FILL_W-1:0]  fill_new;
	logic [PTR_W-1:0]   ptr_new;

	assign s_tready = (state_q == F_IDLE) && !q_full;
	assign accept   = s_tvalid && s_tready;

	// slots at or above the fill count were never written and read as zero
	assign ring_full = (fill_q == FILL_W'(WINDOW_LEN));
	assign oldest    = ring_full ? ram_rdata : '0;
	assign total_new = total_q - TOTAL_W'(oldest) + TOTAL_W'(pulses_q);
	assign fill_new  = ring_full ? fill_q : fill_q + 1'b1;
	assign ptr_new   = (ptr_q == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_q + 1'b1;

	assign q_push = (state_q == F_UPDATE);
	assign q_data = {fill_new, total_new, pulses_q};

	grwr_ram #(
		.WIDTH(PULSE_W),
		.DEPTH(WINDOW_LEN),
		.AW   (PTR_W)
	) u_ring (
		.clk  (clk),
		.we   (q_push),
		.waddr(ptr_q),
		.wdata(pulses_q),
		.re   (accept),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_d = F_UPDATE;
				end
			end
			F_UPDATE: begin
				state_d = F_IDLE;
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			fill_q  <= '0;
			total_q <= '0;
		end else if (q_push) begin
			ptr_q   <= ptr_new;
			fill_q  <= fill_new;
			total_q <= total_new;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pulses_q <= s_tdata[EDGE_W-1:1];
		end
	end

endmodule

[rtl/grwr_fifo.sv]
module grwr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [AW:0]      count_q;

	assign full  = (count_q == (AW + 1)'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[rtl/grwr_div.sv]
module grwr_div #(
	parameter int NUM_W = 24,
	parameter int DEN_W = 16,
	parameter int CNT_W = $clog2(NUM_W + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] rem_init,
	input  logic [DEN_W-1:0] den,
	input  logic [CNT_W-1:0] steps,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q, den_q;
	logic [NUM_W-1:0] num_q, quot_q;

	logic [DEN_W:0]   trial, diff;
	logic             ge;
	logic [DEN_W-1:0] rem_next;

	// one restoring step per cycle, numerator bits enter msb first
	assign trial    = {rem_q, num_q[NUM_W-1]};
	assign ge       = (trial >= {1'b0, den_q});
	assign diff     = trial - {1'b0, den_q};
	assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

	assign done = done_q;
	assign quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			den_q  <= den;
			num_q  <= num;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_next;
			num_q  <= num_q << 1;
			quot_q <= {quot_q[NUM_W-2:0], ge};
		end
	end

endmodule

[rtl/grwr_back.sv]
module grwr_back
	import grwr_pkg::*;
#(
	parameter int TOTAL_W = total_width(WINDOW_LEN_DEF),
	parameter int FILL_W  = $clog2(WINDOW_LEN_DEF + 1),
	parameter int ITEM_W  = PULSE_W + TOTAL_W + FILL_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	output logic                  q_pop,
	input  logic [ITEM_W-1:0]     q_data,
	input  logic [CFG_W-1:0]      cfg,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [PULSE_W-1:0]    out_pulses,
	output logic [AVG_W-1:0]      out_avg,
	output logic [DOSE_W-1:0]     out_dose,
	output logic [FILL_OUT_W-1:0] out_fill
);

	localparam int A_W   = TOTAL_W + AVG_FRAC;
	localparam int DIV_W = (A_W > DOSE_W) ? A_W : DOSE_W;
	localparam int CNT_W = $clog2(DIV_W + 1);
	localparam int FX_W  = (FILL_W > FILL_OUT_W) ? FILL_W : FILL_OUT_W;
	localparam int HI_W  = DOSE_NUM_W - DOSE_W;

	back_state_t state_q, state_d;

	logic [PULSE_W-1:0]    pulses_q;
	logic [FILL_W-1:0]     fill_q;
	logic [AVG_W-1:0]      avg_q;
	logic [DOSE_NUM_W-1:0] dose_num_q;
	logic [DOSE_W-1:0]     dose_q;
	logic                  m_tvalid_q;
	logic [PULSE_W-1:0]    out_pulses_q;
	logic [AVG_W-1:0]      out_avg_q;
	logic [DOSE_W-1:0]     out_dose_q;
	logic [FILL_OUT_W-1:0] out_fill_q;

	logic [PULSE_W-1:0] item_pulses;
	logic [TOTAL_W-1:0] item_total;
	logic [FILL_W-1:0]  item_fill;
	logic [A_W-1:0]     avg_num;
	logic [HI_W-1:0]    dose_hi;
	logic               dose_sat;
	logic               out_free;
	logic [FX_W-1:0]    fill_x;

	logic             div_start, div_done;
	logic [DIV_W-1:0] div_num, div_quot;
	logic [CFG_W-1:0] div_rem, div_den;
	logic [CNT_W-1:0] div_steps;

	assign item_pulses = q_data[PULSE_W-1:0];
	assign item_total  = q_data[PULSE_W +: TOTAL_W];
	assign item_fill   = q_data[PULSE_W + TOTAL_W +: FILL_W];
	assign avg_num     = {item_total, {AVG_FRAC{1'b0}}};

	// quotient overflows 24 bits exactly when the top bits reach the divisor
	assign dose_hi  = dose_num_q[DOSE_NUM_W-1:DOSE_W];
	assign dose_sat = (CFG_W'(dose_hi) >= cfg);
	assign out_free = !m_tvalid_q || m_tready;
	assign q_pop    = (state_q == B_IDLE) && !q_empty;
	assign fill_x   = FX_W'(fill_q);

	// operand select for the shared divider
	always_comb begin
		div_num   = DIV_W'(avg_num) << (DIV_W - A_W);
		div_rem   = '0;
		div_den   = CFG_W'(item_fill);
		div_steps = CNT_W'(A_W);
		if (state_q == B_SCALE_CHK) begin
			div_num   = DIV_W'(dose_num_q[DOSE_W-1:0]) << (DIV_W - DOSE_W);
			div_rem   = CFG_W'(dose_hi);
			div_den   = cfg;
			div_steps = CNT_W'(DOSE_W);
		end
		div_start = q_pop || ((state_q == B_SCALE_CHK) && !dose_sat);
	end

	grwr_div #(
		.NUM_W(DIV_W),
		.DEN_W(CFG_W),
		.CNT_W(CNT_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num     (div_num),
		.rem_init(div_rem),
		.den     (div_den),
		.steps   (div_steps),
		.done    (div_done),
		.quot    (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					state_d = B_AVG;
				end
			end
			B_AVG: begin
				if (div_done) begin
					state_d = B_SCALE_MUL;
				end
			end
			B_SCALE_MUL: begin
				state_d = B_SCALE_CHK;
			end
			B_SCALE_CHK: begin
				state_d = dose_sat ? B_OUT : B_DOSE;
			end
			B_DOSE: begin
				if (div_done) begin
					state_d = B_OUT;
				end
			end
			B_OUT: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == B_OUT) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			pulses_q <= item_pulses;
			fill_q   <= item_fill;
		end
		if ((state_q == B_AVG) && div_done) begin
			avg_q <= div_quot[AVG_W-1:0];
		end
		if (state_q == B_SCALE_MUL) begin
			dose_num_q <= (DOSE_NUM_W'(avg_q) << SCALE_SH_HI)
				+ (DOSE_NUM_W'(avg_q) << SCALE_SH_LO);
		end
		if ((state_q == B_SCALE_CHK) && dose_sat) begin
			dose_q <= DOSE_SAT;
		end
		if ((state_q == B_DOSE) && div_done) begin
			dose_q <= div_quot[DOSE_W-1:0];
		end
		if ((state_q == B_OUT) && out_free) begin
			out_pulses_q <= pulses_q;
			out_avg_q    <= avg_q;
			out_dose_q   <= dose_q;
			out_fill_q   <= fill_x[FILL_OUT_W-1:0];
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign out_pulses = out_pulses_q;
	assign out_avg    = out_avg_q;
	assign out_dose   = out_dose_q;
	assign out_fill   = out_fill_q;

endmodule

[rtl/geiger_rolling_window_rate.sv]
// the back takes one request at a time and runs the shared
//   bit-serial divider for the average (TOTAL_W + 8 steps) then the dose (24 steps)
//   a saturated dose skips the second division
// the front takes a request in its idle state while the two-entry queue is not full
// reset: arst_n low clears control state, window is empty, factor returns to 1538
module geiger_rolling_window_rate
	import grwr_pkg::*;
#(
	parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// config write, counts_per_dose_tenths
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_W-1:0]       cfg_data,
	// input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [EDGE_W-1:0]      s_tdata,  // [15:0] raw_edges
	// output stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_OUT_W-1:0] m_tdata   // [14:0] period_pulses, [37:15] average_cpm_q8,
	                                         // [61:38] dose_rate_q16, [67:62] window_fill,
	                                         // [71:68] zero
);

	// ring sum width, fill counter and ring pointer follow the window length
	localparam int TOTAL_W = total_width(WINDOW_LEN);
	localparam int FILL_W  = $clog2(WINDOW_LEN + 1);
	localparam int PTR_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int ITEM_W  = PULSE_W + TOTAL_W + FILL_W;

	logic [CFG_W-1:0] cfg_q;

	// queue between the front (ring update) and the back (divisions)
	logic              q_push, q_pop, q_full, q_empty;
	logic [ITEM_W-1:0] q_wdata, q_rdata;

	logic [PULSE_W-1:0]    out_pulses;
	logic [AVG_W-1:0]      out_avg;
	logic [DOSE_W-1:0]     out_dose;
	logic [FILL_OUT_W-1:0] out_fill;

	// config register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= cfg_data;
		end
	end

	// front: halves the edge count, swaps it into the ring, updates sum and fill
	grwr_front #(
		.WINDOW_LEN(WINDOW_LEN),
		.TOTAL_W   (TOTAL_W),
		.FILL_W    (FILL_W),
		.PTR_W     (PTR_W),
		.ITEM_W    (ITEM_W)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (q_wdata)
	);

	grwr_fifo #(
		.WIDTH(ITEM_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.pop   (q_pop),
		.rdata (q_rdata),
		.full  (q_full),
		.empty (q_empty)
	);

	// back: average = sum * 256 / fill, dose = average * 2560 / factor (saturating), output register
	grwr_back #(
		.TOTAL_W(TOTAL_W),
		.FILL_W (FILL_W),
		.ITEM_W (ITEM_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_data    (q_rdata),
		.cfg       (cfg_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.out_pulses(out_pulses),
		.out_avg   (out_avg),
		.out_dose  (out_dose),
		.out_fill  (out_fill)
	);

	assign m_tdata = TDATA_OUT_W'({out_fill, out_dose, out_avg, out_pulses});

	// the front only pushes when it reserved queue space at accept time
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("queue push while full");

	// the back never pops an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_empty)
		else $error("queue pop while empty");

	// zero average gives zero dose unless the factor is zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (out_avg == '0) && (cfg_q != '0)) |-> (out_dose == '0))
		else $error("nonzero dose for zero average");

endmodule

[tb/geiger_rolling_window_rate_checker.sv]
`timescale 1ns / 100ps

module geiger_rolling_window_rate_checker
	import grwr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [EDGE_W-1:0]      s_tdata,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [TDATA_OUT_W-1:0] m_tdata,
	output int                     fail_count,
	output int                     pending
);

	localparam int WINDOW     = WINDOW_LEN_DEF;
	localparam int DOSE_SCALE = 2560;
	localparam int AVG_LSB    = PULSE_W;
	localparam int DOSE_LSB   = AVG_LSB + AVG_W;
	localparam int FILL_LSB   = DOSE_LSB + DOSE_W;

	typedef struct packed {
		logic [PULSE_W-1:0]    pulses;
		logic [AVG_W-1:0]      avg;
		logic [DOSE_W-1:0]     dose;
		logic [FILL_OUT_W-1:0] fill;
	} rate_result_t;

	rate_result_t      rate_q[$];
	logic [PULSE_W-1:0] ring [WINDOW];
	int unsigned       ring_ptr;
	int unsigned       fill_cnt;
	longint unsigned   win_total;
	logic [CFG_W-1:0]  dose_factor;

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("%0t ns: %s got %0d want %0d", $time, what, got, want);
		fail_count++;
	endtask

	task automatic predict_rate(input logic [EDGE_W-1:0] edges);
		rate_result_t    r;
		longint unsigned avg_full;
		longint unsigned avg_l;
		longint unsigned dose_full;
		r.pulses = edges[EDGE_W-1:1];
		win_total = win_total - ring[ring_ptr] + r.pulses;
		ring[ring_ptr] = r.pulses;
		ring_ptr = (ring_ptr == WINDOW - 1) ? 0 : ring_ptr + 1;
		if (fill_cnt < WINDOW)
			fill_cnt++;
		avg_full = (win_total << AVG_FRAC) / fill_cnt;
		r.avg = avg_full[AVG_W-1:0];
		// zero factor saturates like an overflow
		if (dose_factor == '0) begin
			r.dose = DOSE_SAT;
		end else begin
			avg_l = r.avg;
			dose_full = (avg_l * DOSE_SCALE) / dose_factor;
			r.dose = (dose_full > DOSE_SAT) ? DOSE_SAT : dose_full[DOSE_W-1:0];
		end
		r.fill = fill_cnt[FILL_OUT_W-1:0];
		rate_q.push_back(r);
	endtask

	task automatic check_rate();
		rate_result_t want;
		if (rate_q.size() == 0) begin
			report_mismatch("result with no request pending, pulses",
				m_tdata[PULSE_W-1:0], 0);
		end else begin
			want = rate_q.pop_front();
			if (m_tdata[PULSE_W-1:0] !== want.pulses)
				report_mismatch("period_pulses", m_tdata[PULSE_W-1:0], want.pulses);
			if (m_tdata[AVG_LSB +: AVG_W] !== want.avg)
				report_mismatch("average_cpm_q8", m_tdata[AVG_LSB +: AVG_W], want.avg);
			if (m_tdata[DOSE_LSB +: DOSE_W] !== want.dose)
				report_mismatch("dose_rate_q16", m_tdata[DOSE_LSB +: DOSE_W], want.dose);
			if (m_tdata[FILL_LSB +: FILL_OUT_W] !== want.fill)
				report_mismatch("window_fill", m_tdata[FILL_LSB +: FILL_OUT_W], want.fill);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++)
				ring[i] = '0;
			ring_ptr = 0;
			fill_cnt = 0;
			win_total = 0;
			dose_factor = CFG_RESET;
			rate_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				dose_factor = cfg_data;
			if (m_tvalid && m_tready)
				check_rate();
			if (s_tvalid && s_tready)
				predict_rate(s_tdata);
			pending = rate_q.size();
		end
	end

endmodule

[tb/geiger_rolling_window_rate_tb.sv]
`timescale 1ns / 100ps

module geiger_rolling_window_rate_tb
	import grwr_pkg::*;
();

	localparam int LIMIT_CYCLES = 1000000;  // far above the slowest correct run
	localparam int HOLD_CYCLES  = 600;      // long receiver hold-off
	localparam int DRAIN_CYCLES = 80;       // settle time after the last result
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 200;
	localparam int PRESS_PHASE  = 4;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_W-1:0]       cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [EDGE_W-1:0]      s_tdata = '0;  // [15:0] raw_edges
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// [14:0] period_pulses, [37:15] average_cpm_q8, [61:38] dose_rate_q16,
	// [67:62] window_fill, [71:68] zero
	logic [TDATA_OUT_W-1:0] m_tdata;

	int unsigned idle_pct = 0;   // sender idle chance per cycle
	int unsigned stall_pct = 0;  // receiver stall chance per cycle
	logic        hold_go = 1'b0;
	logic        hold_off = 1'b0;
	int          fails;
	int          pending;
	int          cycle_cnt;

	always #2 clk = ~clk;

	geiger_rolling_window_rate DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// watches all three channels, predicts and compares
	geiger_rolling_window_rate_checker rate_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fails),
		.pending    (pending)
	);

	// receiver: random stalls, forced low during the hold-off
	always @(negedge clk) begin
		m_tready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
	end

	// long hold-off so the front queue fills and s_tready drops
	initial begin
		wait (hold_go);
		@(negedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_off <= 1'b0;
	end

	// watchdog
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("geiger_rolling_window_rate: mismatch");
		$finish;
	end

	// one edge-count request; valid stays high straight into the next one unless the sender idles
	task automatic send_edges(input logic [EDGE_W-1:0] edges);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= edges;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// factor write, only called with the block idle
	task automatic write_factor(input logic [CFG_W-1:0] factor);
		cfg_valid <= 1'b1;
		cfg_data  <= factor;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drop valid, wait for every result, then let the pipe settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// edge counts: extremes, low geiger-like counts, and full-range noise
	function automatic logic [EDGE_W-1:0] pick_edges();
		case ($urandom_range(0, 7))
			0: return '1;
			1: return '0;
			2, 3: return EDGE_W'($urandom_range(0, 63));
			default: return EDGE_W'($urandom());
		endcase
	endfunction

	logic [EDGE_W-1:0] directed_edges [11] = '{
		16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'hFFFF, 16'hFFFE,
		16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA, 16'h0100
	};

	logic [CFG_W-1:0] factor_set [PHASES];

	initial begin
		// factor 1 and 2 push the dose into saturation, 0 is the zero factor case
		factor_set = '{16'd1, 16'd0, 16'hFFFF, 16'd1538, 16'd2,
			16'd10, 16'd153, 16'd1538, 16'd1, 16'd1};
		factor_set[8] = CFG_W'($urandom_range(1, 65535));
		factor_set[9] = CFG_W'($urandom());

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed requests at the reset factor, window starts empty
		foreach (directed_edges[i])
			send_edges(directed_edges[i]);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			write_factor(factor_set[p]);
			// idling mode cycles: none, sender, receiver, both
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 66; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 66; end
				default: begin idle_pct = 35; stall_pct = 35; end
			endcase
			if (p == PRESS_PHASE)
				hold_go = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_edges(pick_edges());
			drain();
		end

		if (fails == 0 && pending == 0)
			$display("geiger_rolling_window_rate: match");
		else
			$display("geiger_rolling_window_rate: mismatch");
		$finish;
	end

endmodule

[sim.f]
rtl/grwr_pkg.sv
rtl/grwr_ram.sv
rtl/grwr_front.sv
rtl/grwr_fifo.sv
rtl/grwr_div.sv
rtl/grwr_back.sv
rtl/geiger_rolling_window_rate.sv
tb/geiger_rolling_window_rate_checker.sv
tb/geiger_rolling_window_rate_tb.sv
